FILE: rtl/sdwp_pkg.sv
// Shared types and constants of the stereo disparity to world point block.
`default_nettype none

package sdwp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_U      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_V      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_COS_SIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_OFFSET = 3'd6;

  localparam logic [15:0] RST_FOCAL_X  = 16'd16384;
  localparam logic [15:0] RST_FOCAL_Y  = 16'd16384;
  localparam logic [15:0] RST_BASELINE = 16'd120;
  localparam logic [10:0] RST_CENTER_U = 11'd640;
  localparam logic [10:0] RST_CENTER_V = 11'd480;
  localparam logic [15:0] RST_COS      = 16'd16384;
  localparam logic [15:0] RST_SIN      = 16'd0;
  localparam logic [15:0] RST_OFFSET   = 16'd0;

  // divider geometry: one quotient bit per stage
  localparam int DIV_NUM_W   = 48;
  localparam int DIV_DEN_D_W = 12;
  localparam int DIV_DEN_Y_W = 28;

  // square root: two radicand bits per stage
  localparam int SQ_W     = 64;
  localparam int SQ_STEPS = 32;
  localparam int ROOT_W   = 32;

  typedef struct packed {
    logic [10:0] pixel_col;
    logic [10:0] pixel_row;
    logic [11:0] disparity;
  } pix_in_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic        [30:0] cam_z;
    logic        [30:0] cam_distance;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic        [30:0] world_distance;
  } point_out_t;

endpackage

`default_nettype wire

FILE: rtl/sdwp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module sdwp_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 28
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  // numerator bits shift out at the top while quotient bits shift in below
  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign nq_in  = num;
      assign rem_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign nq_in  = nq_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[k]  <= {nq_in[NUM_W-2:0], ge};
        rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = nq_r[NUM_W-1];

endmodule

`default_nettype wire

FILE: rtl/sdwp_sqrt.sv
// Pipelined integer square root with remainder, two radicand bits per stage.
`default_nettype none

module sdwp_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sdwp_pkg::SQ_W-1:0]   sq_in,
  output logic [sdwp_pkg::ROOT_W-1:0] root,
  output logic [sdwp_pkg::ROOT_W:0]   rem
);

  localparam int W = sdwp_pkg::SQ_W;
  localparam int N = sdwp_pkg::SQ_STEPS;

  logic [W-1:0] x_r [N];
  logic [W-1:0] r_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [W-1:0] BIT_K = W'(1) << (W - 2 - 2 * k);
    logic [W-1:0] x_in;
    logic [W-1:0] r_in;
    logic [W-1:0] sum;
    logic         ge;

    if (k == 0) begin : g_first
      assign x_in = sq_in;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_r[k-1];
      assign r_in = r_r[k-1];
    end

    assign sum = r_in + BIT_K;
    assign ge  = x_in >= sum;

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k] <= ge ? (x_in - sum) : x_in;
        r_r[k] <= ge ? ((r_in >> 1) + BIT_K) : (r_in >> 1);
      end
    end
  end

  // final root is below 2^32 and the remainder at most twice that
  assign root = r_r[N-1][sdwp_pkg::ROOT_W-1:0];
  assign rem  = x_r[N-1][sdwp_pkg::ROOT_W:0];

endmodule

`default_nettype wire

FILE: rtl/stereo_disparity_to_world_point.sv
// Stereo triangulation of one pixel per clock into camera and world points.
//
// Takes one pixel (column, row, disparity in sixteenths) per clock and returns one
// point per clock. The depth and both lateral coordinates come from the 48-stage
// bit-per-cycle dividers, and both distances from the 32-stage square roots. The
// whole pipeline holds while a finished point waits with out_stall high; in_stall
// follows it. Configuration writes are taken in any cycle (cfg_ready is tied high) but
// should only be made while no pixel is in flight, as the registers are read at
// several stages down the pipeline.
`default_nettype none

module stereo_disparity_to_world_point (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sdwp_pkg::pix_in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sdwp_pkg::point_out_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sdwp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdwp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DIV_LAT   = sdwp_pkg::DIV_NUM_W;
  localparam int NW        = sdwp_pkg::DIV_NUM_W;
  localparam int P_DIV_IN  = 3;
  localparam int P_DIV_OUT = P_DIV_IN + DIV_LAT;
  localparam int P_S4      = P_DIV_OUT + 1;
  localparam int P_S10     = P_S4 + 6;
  localparam int P_SQ_OUT  = P_S10 + sdwp_pkg::SQ_STEPS;
  localparam int CTL_LEN   = P_SQ_OUT + 1;
  localparam int SQN       = sdwp_pkg::SQ_STEPS;
  localparam int RW        = sdwp_pkg::ROOT_W;

  localparam logic signed [39:0] S32_MAX = 40'sd2147483647;
  localparam logic signed [39:0] S32_MIN = -40'sd2147483648;
  localparam logic [30:0]        U31_MAX = 31'h7FFFFFFF;

  typedef struct packed {
    logic v;
    logic dz;
    logic sx;
    logic sy;
  } ctl_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [30:0] z;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
  } pt_t;

  function automatic logic signed [31:0] sat_s32(input logic signed [39:0] v);
    if (v > S32_MAX) begin
      sat_s32 = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      sat_s32 = 32'sh80000000;
    end else begin
      sat_s32 = v[31:0];
    end
  endfunction

  // signed saturation of a sign and quotient magnitude
  function automatic logic signed [31:0] sat_q(input logic neg, input logic [NW-1:0] mag);
    if (neg) begin
      sat_q = (mag >= NW'(32'h80000000)) ? 32'sh80000000 : (32'd0 - mag[31:0]);
    end else begin
      sat_q = (mag > NW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : mag[31:0];
    end
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? (32'd0 - v) : v;
  endfunction

  // round to nearest from floor root and remainder, then clamp
  function automatic logic [30:0] rnd_root(input logic [RW-1:0] r, input logic [RW:0] x);
    logic [RW:0] rr;
    rr = {1'b0, r} + (RW+1)'(x > {1'b0, r});
    rnd_root = (rr > (RW+1)'(U31_MAX)) ? U31_MAX : rr[30:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [15:0]        focal_x_r, focal_y_r, baseline_r;
  logic [10:0]        center_u_r, center_v_r;
  logic signed [15:0] cos_r, sin_r, ox_r, oy_r, oz_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= sdwp_pkg::RST_FOCAL_X;
      focal_y_r  <= sdwp_pkg::RST_FOCAL_Y;
      baseline_r <= sdwp_pkg::RST_BASELINE;
      center_u_r <= sdwp_pkg::RST_CENTER_U;
      center_v_r <= sdwp_pkg::RST_CENTER_V;
      cos_r      <= sdwp_pkg::RST_COS;
      sin_r      <= sdwp_pkg::RST_SIN;
      ox_r       <= sdwp_pkg::RST_OFFSET;
      oy_r       <= sdwp_pkg::RST_OFFSET;
      oz_r       <= sdwp_pkg::RST_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sdwp_pkg::CFG_FOCAL_X:  focal_x_r  <= cfg_data[15:0];
        sdwp_pkg::CFG_FOCAL_Y:  focal_y_r  <= cfg_data[15:0];
        sdwp_pkg::CFG_BASELINE: baseline_r <= cfg_data[15:0];
        sdwp_pkg::CFG_CENTER_U: center_u_r <= cfg_data[10:0];
        sdwp_pkg::CFG_CENTER_V: center_v_r <= cfg_data[10:0];
        sdwp_pkg::CFG_TILT_COS_SIN: begin
          cos_r <= cfg_data[15:0];
          sin_r <= cfg_data[31:16];
        end
        sdwp_pkg::CFG_CAMERA_OFFSET: begin
          ox_r <= cfg_data[15:0];
          oy_r <= cfg_data[31:16];
          oz_r <= cfg_data[47:32];
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic en;
  logic out_valid_r;
  ctl_t ctl_r [CTL_LEN];
  ctl_t ctl_in;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign out_valid = out_valid_r;

  logic [11:0] dc_c, dr_c;
  logic [10:0] adc_c, adr_c;

  assign dc_c  = {1'b0, in_data.pixel_col} - {1'b0, center_u_r};
  assign dr_c  = {1'b0, in_data.pixel_row} - {1'b0, center_v_r};
  assign adc_c = dc_c[11] ? 11'(12'd0 - dc_c) : dc_c[10:0];
  assign adr_c = dr_c[11] ? 11'(12'd0 - dr_c) : dr_c[10:0];

  assign ctl_in = '{v: in_valid, dz: (in_data.disparity != 12'd0), sx: dc_c[11], sy: dr_c[11]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CTL_LEN; k++) ctl_r[k] <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl_r[0] <= ctl_in;
      for (int k = 1; k < CTL_LEN; k++) ctl_r[k] <= ctl_r[k-1];
      out_valid_r <= ctl_r[P_SQ_OUT].v;
    end
  end

  // ---------------------------------------------------------------- S0..S3
  logic [11:0] s0_d_r, s1_d_r, s2_d_r, s3_d_r;
  logic [10:0] s0_adc_r, s0_adr_r, s1_adr_r;
  logic [31:0] s1_pfb_r, s2_mz_r;
  logic [27:0] s1_dd_r, s2_dd_r, s3_dd_r;
  logic [30:0] s1_mx_r, s2_mx_r;
  logic [46:0] s2_my_r;
  logic [NW-1:0] s3_nz_r, s3_nx_r, s3_ny_r;
  logic [15:0] fy_eff;

  assign fy_eff = (focal_y_r == 16'd0) ? 16'd1 : focal_y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_d_r   <= in_data.disparity;
      s0_adc_r <= adc_c;
      s0_adr_r <= adr_c;

      s1_d_r   <= s0_d_r;
      s1_pfb_r <= 32'(focal_x_r) * 32'(baseline_r);
      s1_dd_r  <= 28'(s0_d_r) * 28'(fy_eff);
      s1_mx_r  <= {27'(baseline_r) * 27'(s0_adc_r), 4'd0};
      s1_adr_r <= s0_adr_r;

      s2_d_r   <= s1_d_r;
      s2_dd_r  <= s1_dd_r;
      s2_mz_r  <= s1_pfb_r;
      s2_mx_r  <= s1_mx_r;
      s2_my_r  <= {43'(s1_pfb_r) * 43'(s1_adr_r), 4'd0};

      // half the divisor added for round-half-away on magnitudes
      s3_d_r   <= s2_d_r;
      s3_dd_r  <= s2_dd_r;
      s3_nz_r  <= NW'(s2_mz_r) + NW'(s2_d_r[11:1]);
      s3_nx_r  <= NW'(s2_mx_r) + NW'(s2_d_r[11:1]);
      s3_ny_r  <= NW'(s2_my_r) + NW'(s2_dd_r[27:1]);
    end
  end

  logic [NW-1:0] qz, qx, qy;

  sdwp_div #(.NUM_W(NW), .DEN_W(sdwp_pkg::DIV_DEN_D_W)) u_div_z (
    .clk(clk), .en(en), .num(s3_nz_r), .den(s3_d_r), .quo(qz)
  );

  sdwp_div #(.NUM_W(NW), .DEN_W(sdwp_pkg::DIV_DEN_D_W)) u_div_x (
    .clk(clk), .en(en), .num(s3_nx_r), .den(s3_d_r), .quo(qx)
  );

  sdwp_div #(.NUM_W(NW), .DEN_W(sdwp_pkg::DIV_DEN_Y_W)) u_div_y (
    .clk(clk), .en(en), .num(s3_ny_r), .den(s3_dd_r), .quo(qy)
  );

  // ---------------------------------------------------------------- S4..S10
  pt_t s4_pt_r, s5_pt_r, s6_pt_r, s7_pt_r, s8_pt_r, s9_pt_r, s10_pt_r;
  logic signed [47:0] s5_zc_r, s5_ys_r, s5_yc_r, s5_zs_r;
  logic [63:0]        s5_xsq_r, s5_ysq_r, s5_zsq_r;
  logic signed [48:0] s6_a_r, s6_b_r;
  logic [63:0]        s6_cs_r, s7_cs_r, s8_cs_r, s9_cs_r, s10_cs_r;
  logic [34:0]        s7_qa_r, s7_qb_r;
  logic               s7_an_r, s7_bn_r;
  logic [63:0]        s9_wxsq_r, s9_wysq_r, s9_wzsq_r, s10_ws_r;

  logic signed [31:0] z_s;
  logic [31:0]        ax_c, ay_c;
  logic [48:0]        ma_c, mb_c, ta_c, tb_c;
  logic signed [39:0] va_c, vb_c;

  assign z_s  = signed'({1'b0, s4_pt_r.z});
  assign ax_c = abs32(s4_pt_r.x);
  assign ay_c = abs32(s4_pt_r.y);
  assign ma_c = s6_a_r[48] ? (49'd0 - s6_a_r) : s6_a_r;
  assign mb_c = s6_b_r[48] ? (49'd0 - s6_b_r) : s6_b_r;
  assign ta_c = ma_c + 49'd8192;
  assign tb_c = mb_c + 49'd8192;
  assign va_c = s7_an_r ? (40'sd0 - signed'(40'(s7_qa_r))) : signed'(40'(s7_qa_r));
  assign vb_c = s7_bn_r ? (40'sd0 - signed'(40'(s7_qb_r))) : signed'(40'(s7_qb_r));

  always_ff @(posedge clk) begin
    if (en) begin
      s4_pt_r.x  <= sat_q(ctl_r[P_DIV_OUT].sx, qx);
      s4_pt_r.y  <= sat_q(ctl_r[P_DIV_OUT].sy, qy);
      s4_pt_r.z  <= (qz > NW'(U31_MAX)) ? U31_MAX : qz[30:0];
      s4_pt_r.wx <= '0;
      s4_pt_r.wy <= '0;
      s4_pt_r.wz <= '0;

      s5_pt_r.x  <= s4_pt_r.x;
      s5_pt_r.y  <= s4_pt_r.y;
      s5_pt_r.z  <= s4_pt_r.z;
      s5_pt_r.wx <= sat_s32(40'(s4_pt_r.x) + 40'(ox_r));
      s5_pt_r.wy <= s4_pt_r.wy;
      s5_pt_r.wz <= s4_pt_r.wz;
      s5_zc_r    <= z_s * cos_r;
      s5_ys_r    <= s4_pt_r.y * sin_r;
      s5_yc_r    <= s4_pt_r.y * cos_r;
      s5_zs_r    <= z_s * sin_r;
      s5_xsq_r   <= 64'(ax_c) * 64'(ax_c);
      s5_ysq_r   <= 64'(ay_c) * 64'(ay_c);
      s5_zsq_r   <= 64'(s4_pt_r.z) * 64'(s4_pt_r.z);

      s6_pt_r    <= s5_pt_r;
      s6_a_r     <= 49'(s5_zc_r) + 49'(s5_ys_r);
      s6_b_r     <= 49'(s5_yc_r) - 49'(s5_zs_r);
      s6_cs_r    <= s5_xsq_r + s5_ysq_r + s5_zsq_r;

      // divide by 2^14, half away from zero
      s7_pt_r    <= s6_pt_r;
      s7_qa_r    <= ta_c[48:14];
      s7_qb_r    <= tb_c[48:14];
      s7_an_r    <= s6_a_r[48];
      s7_bn_r    <= s6_b_r[48];
      s7_cs_r    <= s6_cs_r;

      s8_pt_r.x  <= s7_pt_r.x;
      s8_pt_r.y  <= s7_pt_r.y;
      s8_pt_r.z  <= s7_pt_r.z;
      s8_pt_r.wx <= s7_pt_r.wx;
      s8_pt_r.wz <= sat_s32(va_c + 40'(oz_r));
      s8_pt_r.wy <= sat_s32(vb_c + 40'(oy_r));
      s8_cs_r    <= s7_cs_r;

      s9_pt_r    <= s8_pt_r;
      s9_wxsq_r  <= 64'(abs32(s8_pt_r.wx)) * 64'(abs32(s8_pt_r.wx));
      s9_wysq_r  <= 64'(abs32(s8_pt_r.wy)) * 64'(abs32(s8_pt_r.wy));
      s9_wzsq_r  <= 64'(abs32(s8_pt_r.wz)) * 64'(abs32(s8_pt_r.wz));
      s9_cs_r    <= s8_cs_r;

      s10_pt_r   <= s9_pt_r;
      s10_ws_r   <= s9_wxsq_r + s9_wysq_r + s9_wzsq_r;
      s10_cs_r   <= s9_cs_r;
    end
  end

  // ---------------------------------------------------------------- roots
  logic [RW-1:0] cam_root, world_root;
  logic [RW:0]   cam_rem, world_rem;

  sdwp_sqrt u_sqrt_cam (
    .clk(clk), .en(en), .sq_in(s10_cs_r), .root(cam_root), .rem(cam_rem)
  );

  sdwp_sqrt u_sqrt_world (
    .clk(clk), .en(en), .sq_in(s10_ws_r), .root(world_root), .rem(world_rem)
  );

  pt_t spt_r [SQN];

  always_ff @(posedge clk) begin
    if (en) begin
      spt_r[0] <= s10_pt_r;
      for (int k = 1; k < SQN; k++) spt_r[k] <= spt_r[k-1];
    end
  end

  // ---------------------------------------------------------------- output
  sdwp_pkg::point_out_t out_data_r, res_c;

  always_comb begin
    res_c = '0;
    if (ctl_r[P_SQ_OUT].dz) begin
      res_c.valid_res      = 1'b1;
      res_c.cam_x          = spt_r[SQN-1].x;
      res_c.cam_y          = spt_r[SQN-1].y;
      res_c.cam_z          = spt_r[SQN-1].z;
      res_c.cam_distance   = rnd_root(cam_root, cam_rem);
      res_c.world_x        = spt_r[SQN-1].wx;
      res_c.world_y        = spt_r[SQN-1].wy;
      res_c.world_z        = spt_r[SQN-1].wz;
      res_c.world_distance = rnd_root(world_root, world_rem);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res_c;
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire
